// ===== hdl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared widths, register codes, types and the glyph table of the radix
// seven-segment digit encoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

   // field widths
   localparam int VALUE_WIDTH    = 31;
   localparam int BASE_WIDTH     = 5;
   localparam int COUNT_WIDTH    = 4;
   localparam int POS_WIDTH      = 3;
   localparam int SEG_WIDTH      = 8;
   localparam int REM_WIDTH      = 4;
   localparam int MAX_DIGITS     = 8;

   // bit-serial divider step counter
   localparam int DIV_CNT_WIDTH  = 5;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_STEPS = DIV_CNT_WIDTH'(VALUE_WIDTH);

   // configuration port
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NUMBER_BASE  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COMMON_ANODE = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIGIT_COUNT  = 2'd2;

   localparam logic [BASE_WIDTH-1:0]  BASE_MIN    = 5'd2;
   localparam logic [BASE_WIDTH-1:0]  BASE_MAX    = 5'd16;
   localparam logic [BASE_WIDTH-1:0]  BASE_RESET  = 5'd10;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MIN   = 4'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = COUNT_WIDTH'(MAX_DIGITS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 4'd4;

   localparam logic [SEG_WIDTH-1:0] DOT_BIT = 8'h80;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // hexadecimal seven-segment symbol, segments G..A in bits 6..0
   function automatic logic [SEG_WIDTH-1:0] glyph(input logic [REM_WIDTH-1:0] sym);
      logic [SEG_WIDTH-1:0] pat;
      case (sym)
         4'h0:    pat = 8'h3F;
         4'h1:    pat = 8'h06;
         4'h2:    pat = 8'h5B;
         4'h3:    pat = 8'h4F;
         4'h4:    pat = 8'h66;
         4'h5:    pat = 8'h6D;
         4'h6:    pat = 8'h7D;
         4'h7:    pat = 8'h07;
         4'h8:    pat = 8'h7F;
         4'h9:    pat = 8'h67;
         4'hA:    pat = 8'h77;
         4'hB:    pat = 8'h7C;
         4'hC:    pat = 8'h39;
         4'hD:    pat = 8'h5E;
         4'hE:    pat = 8'h79;
         4'hF:    pat = 8'h71;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

// ===== hdl/rsd_if.sv =====
// ----------------------------------------------------------------------------
// rsd_if
// Valid/ready channels of the encoder: the request item and the result item.
// ----------------------------------------------------------------------------
interface rsd_req_if;
   import rsd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;
   logic                   dot_enable;
   logic [POS_WIDTH-1:0]   dot_position;

   modport source (output valid, value, dot_enable, dot_position, input ready);
   modport sink   (input valid, value, dot_enable, dot_position, output ready);
endinterface

interface rsd_rsp_if;
   import rsd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [SEG_WIDTH-1:0] segment_pattern;
   logic [POS_WIDTH-1:0] digit_index;
   logic                 last_digit;
   logic                 rejected;

   modport source (output valid, segment_pattern, digit_index, last_digit, rejected,
                   input ready);
   modport sink   (input valid, segment_pattern, digit_index, last_digit, rejected,
                   output ready);
endinterface

// ===== hdl/rsd_divider.sv =====
// ----------------------------------------------------------------------------
// rsd_divider
// Restoring divider, one quotient bit per cycle. Splits off one digit of the
// value: quotient and remainder by a small base.
// ----------------------------------------------------------------------------
module rsd_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rsd_pkg::VALUE_WIDTH-1:0]   dividend,
   input  logic [rsd_pkg::BASE_WIDTH-1:0]    divisor,
   output logic [rsd_pkg::VALUE_WIDTH-1:0]   quotient,
   output logic [rsd_pkg::REM_WIDTH-1:0]     remainder,
   output rsd_pkg::div_status_type           status
);
   import rsd_pkg::*;

   logic [VALUE_WIDTH-1:0]   quo_ff, quo_in;
   logic [REM_WIDTH-1:0]     rem_ff, rem_in;
   logic [BASE_WIDTH-1:0]    div_ff, div_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   // partial remainder with the next dividend bit brought down
   logic [BASE_WIDTH-1:0] trial;
   logic [BASE_WIDTH-1:0] diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits  = (trial >= div_ff);
   assign diff  = trial - div_ff;

   // next state
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits in REM_WIDTH bits
         rem_in = fits ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // checks
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff))
      else $error("divider done while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider did not start");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff) && $past(cnt_ff) == DIV_CNT_WIDTH'(1))
      else $error("divider finished early");

endmodule

// ===== hdl/radix_seven_segment_digit_encoder_top.sv =====
// ----------------------------------------------------------------------------
// radix_seven_segment_digit_encoder_top
// Splits a value into digits of a configured base, least significant first,
// and emits one seven-segment pattern per digit, or one rejected result.
//
//   channel  dir  payload                                            item is
//   req_ch   in   value, dot_enable, dot_position                    update
//   rsp_ch   out  segment_pattern, digit_index, last_digit, rejected one digit
//   csr_*    in   csr_we, csr_index, csr_data                        reg write
//
// Each digit runs through the divider steps (one quotient bit per cycle); then
// the sequencer sees the divider finish and, once the output is free, loads the
// output register, which also starts the divider on the next digit.
// Reset is synchronous; it restores base 10, common cathode and four digits.
// The block takes a new item once the last digit of the previous one is in
// the output register; a stalled output holds the next digit in the divider.
// ----------------------------------------------------------------------------
module radix_seven_segment_digit_encoder_top (
   input  logic                                clock,
   input  logic                                reset,
   rsd_req_if.sink                             req_ch,
   rsd_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [rsd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [rsd_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import rsd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT,
      S_REJECT
   } state_type;

   // configuration registers
   logic [BASE_WIDTH-1:0]  base_ff;
   logic                   anode_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         anode_ff <= 1'b0;
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUMBER_BASE: begin
               if (csr_data >= BASE_MIN && csr_data <= BASE_MAX) begin
                  base_ff <= csr_data;
               end
            end
            CSR_COMMON_ANODE: anode_ff <= csr_data[0];
            CSR_DIGIT_COUNT: begin
               if (csr_data[COUNT_WIDTH-1:0] >= COUNT_MIN &&
                   csr_data[COUNT_WIDTH-1:0] <= COUNT_MAX) begin
                  count_ff <= csr_data[COUNT_WIDTH-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // sequencer state and registered outputs
   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   dot_en_ff, dot_en_in;
   logic [POS_WIDTH-1:0]   dot_pos_ff, dot_pos_in;
   logic [POS_WIDTH-1:0]   digit_ff, digit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEG_WIDTH-1:0]   seg_ff, seg_in;
   logic [POS_WIDTH-1:0]   idx_ff, idx_in;
   logic                   last_ff, last_in;
   logic                   rej_ff, rej_in;

   // divider hookup
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [REM_WIDTH-1:0]   div_remainder;
   div_status_type         div_status;

   rsd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (base_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   logic                   out_free;
   logic                   is_last;
   logic                   dot_reject;
   logic [SEG_WIDTH-1:0]   digit_pat;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign is_last    = ({1'b0, digit_ff} == (cnt_ff - 1'b1));
   assign dot_reject = req_ch.dot_enable &&
                       ({1'b0, req_ch.dot_position} > (count_ff - 1'b1));

   // pattern of the digit just split off: glyph, dot, polarity
   always_comb begin
      digit_pat = glyph(div_remainder);
      if (dot_en_ff && digit_ff == dot_pos_ff) begin
         digit_pat = digit_pat | DOT_BIT;
      end
      if (anode_ff) begin
         digit_pat = ~digit_pat;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dot_en_in    = dot_en_ff;
      dot_pos_in   = dot_pos_ff;
      digit_in     = digit_ff;
      rsp_valid_in = rsp_valid_ff;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rej_in       = rej_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            div_dividend = req_ch.value;
            if (req_ch.valid) begin
               cnt_in     = count_ff;
               dot_en_in  = req_ch.dot_enable;
               dot_pos_in = req_ch.dot_position;
               digit_in   = '0;
               if (dot_reject) begin
                  state_in = S_REJECT;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               seg_in       = digit_pat;
               idx_in       = digit_ff;
               last_in      = is_last;
               rej_in       = 1'b0;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  digit_in  = digit_ff + 1'b1;
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_REJECT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               seg_in       = '0;
               idx_in       = '0;
               last_in      = 1'b1;
               rej_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff     <= cnt_in;
      dot_en_ff  <= dot_en_in;
      dot_pos_ff <= dot_pos_in;
      digit_ff   <= digit_in;
      seg_ff     <= seg_in;
      idx_ff     <= idx_in;
      last_ff    <= last_in;
      rej_ff     <= rej_in;
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.segment_pattern = seg_ff;
   assign rsp_ch.digit_index     = idx_ff;
   assign rsp_ch.last_digit      = last_ff;
   assign rsp_ch.rejected        = rej_ff;

   // checks
   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rej_ff |-> last_ff && idx_ff == '0 && seg_ff == '0)
      else $error("rejected item is not a lone blank result");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !div_status.busy)
      else $error("divider running while idle");

   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV || state_ff == S_EMIT |-> {1'b0, digit_ff} < cnt_ff)
      else $error("digit index beyond digit count");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

endmodule
